/* rtl/pbd_pkg.sv */
// Shared types and constants for the premultiplied box downscaler.
package pbd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SRC_FORMAT = 2'd2;
  localparam logic [1:0] REG_KEEP_WIDE  = 2'd3;

  // Input modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  // Nibble expansion factor.
  localparam int unsigned NIB_SCALE = 17;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_wr;     // write the input beat into the frame store
    logic pos_start;    // start the output index to x, y division
    logic geo_start;    // start the box bound divisions
    logic acc_clear;    // clear sums and open the box scan
    logic acc_step;     // issue one sample read and advance the scan
    logic div_start;    // start the final divisions
    logic emit;         // present the result
  } pbd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_done;
    logic geo_done;
    logic scan_last;    // current read is the last sample of the box
    logic div_done;
  } pbd_sts_t;

endpackage

/* rtl/pbd_divider.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
module pbd_divider #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW+1:0] trial;

  // Shift in the next numerator bit and try to subtract.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, q_r[NW-1]} - {2'b00, den_r};
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW:0];
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-1:0], q_r[NW-1]};
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

/* rtl/pbd_datapath.sv */
// Datapath: frame store, geometry, box scan, sums and dividers.
module pbd_datapath #(
  parameter int unsigned MAX_SRC_W  = 512,
  parameter int unsigned MAX_SRC_H  = 512,
  parameter int unsigned OUT_CLAMP  = 256,
  parameter int unsigned WIDE_MAX_W = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pbd_pkg::pbd_cmd_t  cmd,
  output pbd_pkg::pbd_sts_t  sts,
  input  logic [31:0]        pixel_word,
  input  logic [9:0]         src_width,
  input  logic [9:0]         src_height,
  input  logic               src_format,
  input  logic               keep_wide,
  output logic [15:0]        out_pixel,
  output logic               last_pixel
);

  localparam int unsigned DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned XW    = $clog2(MAX_SRC_W + 1);
  localparam int unsigned YW    = $clog2(MAX_SRC_H + 1);
  localparam int unsigned TW    = AW + 1;
  localparam int unsigned MW    = (XW > YW ? XW : YW) + 11;
  // Box is at most (sw/cw + 1) by (sh/ch + 1) samples; keep sums generous.
  localparam int unsigned NCW   = TW;
  localparam int unsigned SAW   = NCW + 8;
  localparam int unsigned SCW   = SAW + 8;
  localparam logic [7:0]  NIB_MUL = 8'(pbd_pkg::NIB_SCALE);

  // Clamped geometry.
  logic [XW-1:0] sw, cw;
  logic [YW-1:0] sh, ch;
  logic [TW-1:0] load_total, emit_total;

  always_comb begin
    if (src_width == 10'd0)                       sw = XW'(1);
    else if ({22'd0, src_width} > 32'(MAX_SRC_W)) sw = XW'(MAX_SRC_W);
    else                                          sw = XW'(src_width);
    if (src_height == 10'd0)                       sh = YW'(1);
    else if ({22'd0, src_height} > 32'(MAX_SRC_H)) sh = YW'(MAX_SRC_H);
    else                                           sh = YW'(src_height);
    if (keep_wide && 32'(sw) <= 32'(WIDE_MAX_W))   cw = sw;
    else if (32'(sw) > 32'(OUT_CLAMP))             cw = XW'(OUT_CLAMP);
    else                                           cw = sw;
    if (32'(sh) > 32'(OUT_CLAMP)) ch = YW'(OUT_CLAMP);
    else                          ch = sh;
  end

  assign load_total = TW'(sw) * TW'(sh);
  assign emit_total = TW'(cw) * TW'(ch);

  // Load index and frame store write.
  logic [TW-1:0] load_idx_r, load_idx_nxt, load_cur;
  logic [31:0]   store_mem [DEPTH];
  logic [31:0]   rd_word_r;
  logic [AW-1:0] rd_addr;

  assign load_cur = (load_idx_r >= load_total) ? '0 : load_idx_r;
  always_comb begin
    load_idx_nxt = load_idx_r;
    if (cmd.store_wr) begin
      load_idx_nxt = load_cur + 1'b1;
      if (load_idx_nxt >= load_total) load_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr) store_mem[load_cur[AW-1:0]] <= pixel_word;
    rd_word_r <= store_mem[rd_addr];
  end

  // Output position counter, kept as a linear index.
  logic [TW-1:0] emit_idx_r;
  logic [TW-1:0] e_idx;
  logic          e_wrap;

  assign e_wrap = (emit_idx_r >= emit_total);
  assign e_idx  = e_wrap ? '0 : emit_idx_r;

  // Output x and y from the linear index, by one division by the output width.
  logic          pos_done, pd_r;
  logic [TW-1:0] pos_q, pos_rem;
  logic [XW-1:0] ox_r;
  logic [YW-1:0] oy_r;

  assign pos_rem = e_idx - pos_q * TW'(cw);

  pbd_divider #(.NW(TW), .DW(XW)) u_pos (.clk, .rst_n, .start(cmd.pos_start),
    .num(e_idx), .den(cw), .done(pos_done), .quo(pos_q));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.pos_start) begin
      pd_r <= 1'b0;
    end else begin
      pd_r <= pd_r | pos_done;
    end
    if (pos_done) begin
      ox_r <= pos_rem[XW-1:0];
      oy_r <= pos_q[YW-1:0];
    end
  end
  assign sts.pos_done = pd_r;

  // Box bound divisions: four products over the clamped sizes.
  logic          gdone0, gdone1, gdone2, gdone3;
  logic [MW-1:0] gq0, gq1, gq2, gq3;
  logic [MW-1:0] nx0, nx1, ny0, ny1;
  logic          gd0_r, gd1_r, gd2_r, gd3_r;

  assign nx0 = MW'(ox_r) * MW'(sw);
  assign nx1 = (MW'(ox_r) + 1'b1) * MW'(sw);
  assign ny0 = MW'(oy_r) * MW'(sh);
  assign ny1 = (MW'(oy_r) + 1'b1) * MW'(sh);

  pbd_divider #(.NW(MW), .DW(XW)) u_gx0 (.clk, .rst_n, .start(cmd.geo_start),
    .num(nx0), .den(cw), .done(gdone0), .quo(gq0));
  pbd_divider #(.NW(MW), .DW(XW)) u_gx1 (.clk, .rst_n, .start(cmd.geo_start),
    .num(nx1), .den(cw), .done(gdone1), .quo(gq1));
  pbd_divider #(.NW(MW), .DW(YW)) u_gy0 (.clk, .rst_n, .start(cmd.geo_start),
    .num(ny0), .den(ch), .done(gdone2), .quo(gq2));
  pbd_divider #(.NW(MW), .DW(YW)) u_gy1 (.clk, .rst_n, .start(cmd.geo_start),
    .num(ny1), .den(ch), .done(gdone3), .quo(gq3));

  // All four finish together; latch the done level.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.geo_start) begin
      gd0_r <= 1'b0; gd1_r <= 1'b0; gd2_r <= 1'b0; gd3_r <= 1'b0;
    end else begin
      gd0_r <= gd0_r | gdone0; gd1_r <= gd1_r | gdone1;
      gd2_r <= gd2_r | gdone2; gd3_r <= gd3_r | gdone3;
    end
  end
  assign sts.geo_done = gd0_r & gd1_r & gd2_r & gd3_r;

  // Box scan over the samples.
  logic [XW-1:0] x0, x1, px_r;
  logic [YW-1:0] y0, y1, py_r;
  logic [AW+1:0] row_base_r;
  logic          scan_last;

  assign x0 = gq0[XW-1:0];
  assign y0 = gq2[YW-1:0];
  assign x1 = (gq1[XW-1:0] < x0 + 1'b1) ? x0 + 1'b1 : gq1[XW-1:0];
  assign y1 = (gq3[YW-1:0] < y0 + 1'b1) ? y0 + 1'b1 : gq3[YW-1:0];
  assign scan_last = (px_r + 1'b1 == x1) && (py_r + 1'b1 == y1);
  assign sts.scan_last = scan_last;
  assign rd_addr = AW'(row_base_r + (AW+2)'(px_r));

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      px_r       <= x0;
      py_r       <= y0;
      row_base_r <= (AW+2)'(y0) * (AW+2)'(sw);
    end else if (cmd.acc_step) begin
      if (px_r + 1'b1 == x1) begin
        px_r       <= x0;
        py_r       <= py_r + 1'b1;
        row_base_r <= row_base_r + (AW+2)'(sw);
      end else begin
        px_r <= px_r + 1'b1;
      end
    end
  end

  // Read data arrives in the cycle after a step; it passes the product stage, then the sum stage.
  logic           rd_vld_r;
  logic [7:0]     ca, cr, cg, cb;
  logic [SAW-1:0] sa_r;
  logic [SCW-1:0] sr_r, sg_r, sb_r;
  logic [NCW-1:0] n_r;
  logic [15:0]    pr_r, pg_r, pb_r;
  logic [7:0]     pa_r;
  logic           pv_r;

  always_comb begin
    if (src_format == 1'b0) begin
      ca = 8'(rd_word_r[15:12] * NIB_MUL);
      cr = 8'(rd_word_r[11:8]  * NIB_MUL);
      cg = 8'(rd_word_r[7:4]   * NIB_MUL);
      cb = 8'(rd_word_r[3:0]   * NIB_MUL);
    end else begin
      ca = rd_word_r[31:24];
      cr = rd_word_r[23:16];
      cg = rd_word_r[15:8];
      cb = rd_word_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      pv_r     <= 1'b0;
    end else begin
      rd_vld_r <= cmd.acc_step;
      pv_r     <= rd_vld_r;
    end
    // Product stage.
    pa_r <= ca;
    pr_r <= cr * ca;
    pg_r <= cg * ca;
    pb_r <= cb * ca;
    // Sum stage.
    if (cmd.acc_clear) begin
      sa_r <= '0; sr_r <= '0; sg_r <= '0; sb_r <= '0; n_r <= '0;
    end else if (pv_r) begin
      sa_r <= sa_r + SAW'(pa_r);
      sr_r <= sr_r + SCW'(pr_r);
      sg_r <= sg_r + SCW'(pg_r);
      sb_r <= sb_r + SCW'(pb_r);
      n_r  <= n_r + 1'b1;
    end
  end

  // Final divisions run in parallel.
  logic           dd_a, dd_r, dd_g, dd_b;
  logic [SAW-1:0] qa;
  logic [SCW-1:0] qr, qg, qb;
  logic           da_r, dr_r;

  pbd_divider #(.NW(SAW), .DW(NCW)) u_da (.clk, .rst_n, .start(cmd.div_start),
    .num(sa_r), .den(n_r), .done(dd_a), .quo(qa));
  pbd_divider #(.NW(SCW), .DW(SAW)) u_dr (.clk, .rst_n, .start(cmd.div_start),
    .num(sr_r), .den(sa_r), .done(dd_r), .quo(qr));
  pbd_divider #(.NW(SCW), .DW(SAW)) u_dg (.clk, .rst_n, .start(cmd.div_start),
    .num(sg_r), .den(sa_r), .done(dd_g), .quo(qg));
  pbd_divider #(.NW(SCW), .DW(SAW)) u_db (.clk, .rst_n, .start(cmd.div_start),
    .num(sb_r), .den(sa_r), .done(dd_b), .quo(qb));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.div_start) begin
      da_r <= 1'b0;
      dr_r <= 1'b0;
    end else begin
      da_r <= da_r | dd_a;
      dr_r <= dr_r | (dd_r & dd_g & dd_b);
    end
  end
  assign sts.div_done = da_r & dr_r;

  // Result packing and emit counter.
  logic        zero_a;
  logic [15:0] pix_r;
  logic        last_r;
  assign zero_a = (sa_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_idx_r <= '0;
      emit_idx_r <= '0;
    end else begin
      load_idx_r <= load_idx_nxt;
      if (cmd.emit) begin
        if (e_idx + 1'b1 >= emit_total) begin
          emit_idx_r <= '0;
        end else begin
          emit_idx_r <= e_idx + 1'b1;
        end
      end
    end
    if (cmd.emit) begin
      pix_r  <= {qa[7:4], zero_a ? 4'd0 : qr[7:4], zero_a ? 4'd0 : qg[7:4],
                 zero_a ? 4'd0 : qb[7:4]};
      last_r <= (e_idx + 1'b1 == emit_total);
    end
  end

  assign out_pixel  = pix_r;
  assign last_pixel = last_r;

endmodule

/* rtl/pbd_ctrl.sv */
// Controller state machine sequencing loads and output pixel computation.
module pbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              mode,
  output logic              busy,
  output logic              out_valid,
  output pbd_pkg::pbd_cmd_t cmd,
  input  pbd_pkg::pbd_sts_t sts
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_POS   = 8'b00000010,
    S_GEO   = 8'b00000100,
    S_CLR   = 8'b00001000,
    S_SCAN  = 8'b00010000,
    S_DRAIN = 8'b00100000,
    S_DIV   = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] drain_r, drain_nxt;
  logic       oval_r, oval_nxt;

  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    oval_nxt  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (mode == pbd_pkg::MODE_LOAD) begin
            cmd.store_wr = 1'b1;
          end else begin
            cmd.pos_start = 1'b1;
            state_nxt     = S_POS;
          end
        end
      end
      S_POS: begin
        if (sts.pos_done) begin
          cmd.geo_start = 1'b1;
          state_nxt     = S_GEO;
        end
      end
      S_GEO: begin
        if (sts.geo_done) state_nxt = S_CLR;
      end
      S_CLR: begin
        cmd.acc_clear = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.acc_step = 1'b1;
        if (sts.scan_last) begin
          drain_nxt = 2'd3;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r - 1'b1;
        if (drain_r == 2'd1) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        oval_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      drain_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = oval_r;

endmodule

/* rtl/premultiplied_box_downscaler.sv */
// Top level of the premultiplied-alpha box downscaler.
// A load beat (in_mode 0) is written to the frame store and leaves busy low. An
// output request (in_mode 1) keeps busy high while it runs, in order, the division
// of the output index by the output width, the box bound divisions, the box scan
// (one frame store read per cycle, 1 to 4 samples with the default parameters),
// the drain through the read register, product stage and sum stage, and the final
// divisions of the alpha sum by the sample count and of the weighted color sums by
// the alpha sum. The result beat appears on out_pixel and out_last_pixel for one
// cycle with out_valid high, in the first cycle that busy is low again, and cannot
// be stalled. The user must see that configuration is written only while busy is
// low and no result is outstanding; the block itself does not enforce this.
module premultiplied_box_downscaler #(
  parameter int unsigned MAX_SRC_W  = 512,
  parameter int unsigned MAX_SRC_H  = 512,
  parameter int unsigned OUT_CLAMP  = 256,
  parameter int unsigned WIDE_MAX_W = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_pixel_word,
  output logic        out_valid,
  output logic [15:0] out_pixel,
  output logic        out_last_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  pbd_pkg::pbd_cmd_t cmd;
  pbd_pkg::pbd_sts_t sts;

  // Configuration registers.
  logic [9:0] src_width_r, src_height_r;
  logic       src_format_r, keep_wide_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= 10'd256;
      src_height_r <= 10'd256;
      src_format_r <= 1'b0;
      keep_wide_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pbd_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_data[9:0];
        pbd_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_data[9:0];
        pbd_pkg::REG_SRC_FORMAT: src_format_r <= cfg_data[0];
        pbd_pkg::REG_KEEP_WIDE:  keep_wide_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pbd_ctrl u_ctrl (
    .clk, .rst_n, .start, .mode(in_mode), .busy, .out_valid, .cmd, .sts
  );

  pbd_datapath #(
    .MAX_SRC_W(MAX_SRC_W), .MAX_SRC_H(MAX_SRC_H),
    .OUT_CLAMP(OUT_CLAMP), .WIDE_MAX_W(WIDE_MAX_W)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .pixel_word(in_pixel_word),
    .src_width(src_width_r), .src_height(src_height_r),
    .src_format(src_format_r), .keep_wide(keep_wide_r),
    .out_pixel, .last_pixel(out_last_pixel)
  );

endmodule
